// ----- hw/rtl/utf8tn_pkg.sv -----
// Shared types, constants and byte-coding functions for the UTF-8 title normalizer.
package utf8tn_pkg;

    localparam int QDEPTH  = 8;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCW     = $clog2(QDEPTH + 1);
    localparam int MAX_RES = 3;

    localparam logic [20:0] CP_DIGIT_LO = 21'h30;
    localparam logic [20:0] CP_DIGIT_HI = 21'h39;
    localparam logic [20:0] CP_UPPER_LO = 21'h41;
    localparam logic [20:0] CP_UPPER_HI = 21'h5A;
    localparam logic [20:0] CP_LOWER_LO = 21'h61;
    localparam logic [20:0] CP_LOWER_HI = 21'h7A;
    localparam logic [20:0] CP_CJK_LO   = 21'h4E00;
    localparam logic [20:0] CP_CJK_HI   = 21'h9FFF;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // One group of results from a single input word.
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] data;
        logic            dflag;
        logic            eos;
    } t_res_grp;

    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] data;
    } t_enc;

    // Sequence length of a lead byte: 1 for ASCII, 0 for a stray byte.
    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] len;
        if (!c[7]) begin
            len = 3'd1;
        end else if ((c & LEAD2_MASK) == LEAD2_TAG) begin
            len = 3'd2;
        end else if ((c & LEAD3_MASK) == LEAD3_TAG) begin
            len = 3'd3;
        end else if ((c & LEAD4_MASK) == LEAD4_TAG) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    // Filter, fold and re-encode one code point.
    function automatic t_enc encode_cp(input logic [20:0] cp);
        t_enc e;
        logic is_digit;
        logic is_upper;
        logic is_lower;
        logic is_cjk;
        e        = '0;
        is_digit = (cp >= CP_DIGIT_LO) && (cp <= CP_DIGIT_HI);
        is_upper = (cp >= CP_UPPER_LO) && (cp <= CP_UPPER_HI);
        is_lower = (cp >= CP_LOWER_LO) && (cp <= CP_LOWER_HI);
        is_cjk   = (cp >= CP_CJK_LO) && (cp <= CP_CJK_HI);
        if (is_digit || is_lower) begin
            e.cnt     = 2'd1;
            e.data[0] = cp[7:0];
        end else if (is_upper) begin
            e.cnt     = 2'd1;
            e.data[0] = cp[7:0] | CASE_BIT;
        end else if (is_cjk) begin
            e.cnt     = 2'd3;
            e.data[0] = LEAD3_TAG | {4'h0, cp[15:12]};
            e.data[1] = {2'b10, cp[11:6]};
            e.data[2] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

endpackage

// ----- hw/rtl/utf8_title_normalizer.sv -----
// Lenient UTF-8 decode, keep digits / folded letters / CJK 4E00-9FFF, re-encode to UTF-8.
// Input words are registered, decoded in one pass and written as a group of 0 to 3 result
// words into an 8-word queue; an accepted item waits in the input register until the queue
// has room. One input word is taken per cycle as long as the queue has 3 free
// entries; the queue drains one result word per cycle, and since a three-byte output needs
// at least three input bytes, the sustained rate is one input word per cycle unless the
// receiver stalls. A bare end marker (out_valid low, end_of_string high) is given when the
// final byte of a string yields no output; end_of_string marks the last word of every string.
module utf8_title_normalizer import utf8tn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic       o_end_of_string
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       room;
    logic       fire;
    logic       accept_in;
    t_res_grp   grp;

    assign fire      = r_in_valid && room;
    assign o_stall   = r_in_valid && !room;
    assign accept_in = i_valid && !o_stall;

    always_comb begin
        if (accept_in) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_is_last;
        end
    end

    utf8tn_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_grp   (grp)
    );

    utf8tn_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_grp   (grp),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_byte  (o_out_byte),
        .o_dflag (o_out_valid),
        .o_eos   (o_end_of_string)
    );

endmodule

// ----- hw/rtl/utf8tn_decode.sv -----
// Sequence state and single-pass decode of one byte into a group of up to three results.
module utf8tn_decode import utf8tn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_res_grp   o_grp
);

    logic [1:0]  r_cnt, n_cnt;
    logic [2:0]  r_need, n_need;
    logic [20:0] r_acc, n_acc;
    logic [7:0]  r_seq1, n_seq1;

    logic [2:0]  len_b;
    logic [2:0]  len_x;
    logic [20:0] full_cp;
    logic        done;
    logic [20:0] cp_a;
    logic [20:0] cp_b;
    logic        a_ok;
    logic        b_ok;
    t_enc        enc_a;
    t_enc        enc_b;
    logic [1:0]  na;
    logic [1:0]  nb;
    logic [1:0]  tot;

    always_comb begin
        len_b   = lead_len(i_byte);
        len_x   = lead_len(r_seq1);
        full_cp = {r_acc[14:0], i_byte[5:0]};
        done    = ({1'b0, r_cnt} + 3'd1) >= r_need;

        cp_a = {13'd0, i_byte};
        a_ok = !i_byte[7];
        cp_b = {13'd0, i_byte};
        b_ok = 1'b0;
        if (r_cnt != 2'd0) begin
            if (done) begin
                cp_a = full_cp;
                a_ok = 1'b1;
            end else if (!i_last) begin
                a_ok = 1'b0;
            end else if (r_cnt == 2'd2) begin
                // string ended early: lead dropped, redo the second and final bytes
                if (len_x == 3'd2) begin
                    cp_a = {10'd0, r_seq1[4:0], i_byte[5:0]};
                    a_ok = 1'b1;
                end else if (len_x == 3'd1) begin
                    cp_a = {13'd0, r_seq1};
                    a_ok = 1'b1;
                    b_ok = !i_byte[7];
                end
            end
        end

        enc_a = encode_cp(cp_a);
        enc_b = encode_cp(cp_b);
        na    = a_ok ? enc_a.cnt : 2'd0;
        nb    = b_ok ? enc_b.cnt : 2'd0;
        tot   = na + nb;

        o_grp.data[0] = (na != 2'd0) ? enc_a.data[0] : enc_b.data[0];
        o_grp.data[1] = (na == 2'd3) ? enc_a.data[1] : enc_b.data[0];
        o_grp.data[2] = enc_a.data[2];
        if (tot == 2'd0) begin
            o_grp.data[0] = 8'h00;
        end
        o_grp.cnt   = (i_last && tot == 2'd0) ? 2'd1 : tot;
        o_grp.dflag = (tot != 2'd0);
        o_grp.eos   = i_last;
    end

    always_comb begin
        n_cnt  = 2'd0;
        n_need = r_need;
        n_acc  = r_acc;
        n_seq1 = r_seq1;
        if (r_cnt == 2'd0) begin
            if (!i_last && len_b >= 3'd2) begin
                n_cnt  = 2'd1;
                n_need = len_b;
                case (len_b)
                    3'd2:    n_acc = {16'd0, i_byte[4:0]};
                    3'd3:    n_acc = {17'd0, i_byte[3:0]};
                    default: n_acc = {18'd0, i_byte[2:0]};
                endcase
            end
        end else if (!i_last && !done) begin
            n_cnt = r_cnt + 2'd1;
            n_acc = full_cp;
            if (r_cnt == 2'd1) begin
                n_seq1 = i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_need <= 3'd0;
            r_acc  <= 21'd0;
        end else if (i_fire) begin
            r_cnt  <= n_cnt;
            r_need <= n_need;
            r_acc  <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_seq1 <= n_seq1;
        end
    end

endmodule

// ----- hw/rtl/utf8tn_outq.sv -----
// Result queue: per cycle takes up to three words and hands out one unless stalled.
module utf8tn_outq import utf8tn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_res_grp   i_grp,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte,
    output logic       o_dflag,
    output logic       o_eos
);

    logic [7:0]     r_data [QDEPTH];
    logic           r_flag [QDEPTH];
    logic           r_eos  [QDEPTH];
    logic [QAW-1:0] r_wr, n_wr;
    logic [QAW-1:0] r_rd, n_rd;
    logic [QCW-1:0] r_count, n_count;
    logic           pop;
    logic [1:0]     push_n;

    assign pop     = (r_count != '0) && !i_stall;
    assign push_n  = i_push ? i_grp.cnt : 2'd0;
    assign o_room  = r_count <= QCW'(QDEPTH - MAX_RES);
    assign o_valid = (r_count != '0);
    assign o_byte  = r_data[r_rd];
    assign o_dflag = r_flag[r_rd];
    assign o_eos   = r_eos[r_rd];

    always_comb begin
        n_wr    = r_wr + QAW'(push_n);
        n_rd    = pop ? r_rd + QAW'(1) : r_rd;
        n_count = r_count + QCW'(push_n) - QCW'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (i_push && (2'(k) < i_grp.cnt)) begin
                r_data[r_wr + QAW'(k)] <= i_grp.data[k];
                r_flag[r_wr + QAW'(k)] <= i_grp.dflag;
                r_eos[r_wr + QAW'(k)]  <= i_grp.eos && (2'(k) == i_grp.cnt - 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- sim/utf8_title_normalizer_test.sv -----
// Testbench for utf8_title_normalizer: directed and random strings checked word by word.
module utf8_title_normalizer_test;

    localparam int          STUCK_LIMIT  = 2000;
    localparam int          LONG_HOLD    = 64;
    localparam int          DRAIN_CYCLES = 16;
    localparam logic [20:0] CJK_FIRST    = 21'h4E00;
    localparam logic [20:0] CJK_LAST     = 21'h9FFF;

    typedef struct packed {
        logic [7:0] data;
        logic       dval;
        logic       eos;
    } t_norm_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       i_is_last;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_out_valid;
    logic       o_end_of_string;

    // decoder state mirrored by the predictor
    logic [7:0]  seq_buf [0:3];
    int unsigned seq_cnt;
    int unsigned seq_len;
    logic [20:0] cp_acc;

    logic [7:0]  cp_bytes [$];
    logic [7:0]  str_bytes [$];
    t_norm_word  norm_q [$];

    int unsigned mismatch_count = 0;
    int unsigned words_sent     = 0;
    int unsigned stuck_cycles   = 0;
    bit          tx_idle_en     = 1'b1;
    bit          rx_idle_en     = 1'b1;
    bit          long_hold_req  = 1'b0;

    utf8_title_normalizer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_in_byte       (i_in_byte),
        .i_is_last       (i_is_last),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_out_valid     (o_out_valid),
        .o_end_of_string (o_end_of_string)
    );

    always #1 i_clk = ~i_clk;

    function automatic void add_cp_byte(input logic [7:0] b);
        cp_bytes = {cp_bytes, b};
    endfunction

    function automatic void add_str_byte(input logic [7:0] b);
        str_bytes = {str_bytes, b};
    endfunction

    function automatic void add_norm_word(input t_norm_word w);
        norm_q = {norm_q, w};
    endfunction

    function automatic int unsigned lead_length(input logic [7:0] c);
        casez (c)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 0;
        endcase
    endfunction

    function automatic logic [20:0] lead_payload(input logic [7:0] c, input int unsigned len);
        case (len)
            2:       return {16'd0, c[4:0]};
            3:       return {17'd0, c[3:0]};
            4:       return {18'd0, c[2:0]};
            default: return {13'd0, c};
        endcase
    endfunction

    function automatic void fold_and_encode(input logic [20:0] cp);
        if ((cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h61 && cp <= 21'h7A)) begin
            add_cp_byte(cp[7:0]);
        end else if (cp >= 21'h41 && cp <= 21'h5A) begin
            add_cp_byte(cp[7:0] | 8'h20);
        end else if (cp >= CJK_FIRST && cp <= CJK_LAST) begin
            add_cp_byte({4'hE, cp[15:12]});
            add_cp_byte({2'b10, cp[11:6]});
            add_cp_byte({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void clear_seq();
        for (int k = 0; k < 4; k++) seq_buf[k] = 8'h00;
        seq_cnt = 0;
        seq_len = 0;
        cp_acc  = '0;
    endfunction

    // Expected output words for one accepted input word.
    task automatic normalize_word(input logic [7:0] b, input logic last);
        logic [7:0]  tail [0:3];
        int unsigned m;
        int unsigned i;
        int unsigned k;
        int unsigned n;
        int unsigned len;
        logic [20:0] cp;
        t_norm_word  w;
        cp_bytes.delete();
        if (last) begin
            // re-decode the buffered bytes from scratch; a lead that does not fit is dropped
            m = 0;
            for (k = 0; k < seq_cnt && k < 3; k++) begin
                tail[m] = seq_buf[k];
                m++;
            end
            tail[m] = b;
            m++;
            i = 0;
            while (i < m) begin
                len = lead_length(tail[i]);
                if (len == 0 || i + len > m) begin
                    i++;
                end else begin
                    cp = lead_payload(tail[i], len);
                    for (k = 1; k < len; k++) cp = {cp[14:0], tail[i + k][5:0]};
                    fold_and_encode(cp);
                    i += len;
                end
            end
            clear_seq();
        end else if (seq_cnt == 0) begin
            len = lead_length(b);
            if (len == 1) begin
                fold_and_encode({13'd0, b});
            end else if (len >= 2) begin
                seq_buf[0] = b;
                seq_cnt    = 1;
                seq_len    = len;
                cp_acc     = lead_payload(b, len);
            end
        end else begin
            // any byte inside a sequence counts as a continuation
            if (seq_cnt < 4) seq_buf[seq_cnt] = b;
            seq_cnt++;
            cp_acc = {cp_acc[14:0], b[5:0]};
            if (seq_cnt >= seq_len) begin
                fold_and_encode(cp_acc);
                clear_seq();
            end
        end
        n = (cp_bytes.size() > 3) ? 3 : cp_bytes.size();
        if (last && n == 0) begin
            w.data = 8'h00;
            w.dval = 1'b0;
            w.eos  = 1'b1;
            add_norm_word(w);
        end
        for (k = 0; k < n; k++) begin
            w.data = cp_bytes[k];
            w.dval = 1'b1;
            w.eos  = last && (k + 1 == n);
            add_norm_word(w);
        end
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
        end
    endfunction

    // Predict on input words, then check output words, in one process.
    always @(posedge i_clk) begin : word_check
        t_norm_word want;
        if (i_rst_n && i_valid && !o_stall) normalize_word(i_in_byte, i_is_last);
        if (i_rst_n && o_valid && !i_stall) begin
            if (norm_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word, expected none, actual byte %02h valid %b eos %b",
                         $time, o_out_byte, o_out_valid, o_end_of_string);
            end else begin
                want = norm_q.pop_front();
                check_field("out_byte", want.data, o_out_byte);
                check_field("out_valid", {7'd0, want.dval}, {7'd0, o_out_valid});
                check_field("end_of_string", {7'd0, want.eos}, {7'd0, o_end_of_string});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) stuck_cycles <= 0;
        else stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin : rx_side
        int unsigned burst;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 8);
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_is_last <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_built_string();
        for (int j = 0; j < str_bytes.size(); j++)
            send_word(str_bytes[j], j == str_bytes.size() - 1);
    endtask

    task automatic send_random_string(input bit cjk_heavy);
        int unsigned units;
        int unsigned kind;
        int unsigned n;
        int unsigned cut;
        logic [20:0] cp;
        str_bytes.delete();
        units = $urandom_range(1, 6);
        for (int u = 0; u < units; u++) begin
            kind = cjk_heavy ? ($urandom_range(0, 3) == 0 ? 0 : 4) : $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    case ($urandom_range(0, 2))
                        0:       add_str_byte(8'($urandom_range(8'h30, 8'h39)));
                        1:       add_str_byte(8'($urandom_range(8'h41, 8'h5A)));
                        default: add_str_byte(8'($urandom_range(8'h61, 8'h7A)));
                    endcase
                end
                3: add_str_byte(8'($urandom_range(0, 127)));
                4, 5: begin
                    // mostly inside the kept range, sometimes just outside it
                    cp = cjk_heavy ? 21'($urandom_range(CJK_FIRST, CJK_LAST))
                                   : 21'($urandom_range(21'h4DF0, 21'hA00F));
                    add_str_byte({4'hE, cp[15:12]});
                    add_str_byte({2'b10, cp[11:6]});
                    add_str_byte({2'b10, cp[5:0]});
                end
                6, 7: begin
                    n = $urandom_range(2, 4);
                    case (n)
                        2:       add_str_byte(8'hC0 | 8'($urandom_range(0, 31)));
                        3:       add_str_byte(8'hE0 | 8'($urandom_range(0, 15)));
                        default: add_str_byte(8'hF0 | 8'($urandom_range(0, 7)));
                    endcase
                    for (int j = 1; j < n; j++) begin
                        if ($urandom_range(0, 3) == 0)
                            add_str_byte(8'($urandom_range(0, 255)));
                        else
                            add_str_byte(8'h80 | 8'($urandom_range(0, 63)));
                    end
                end
                8: add_str_byte(8'($urandom_range(0, 255)));
                default: begin
                    // overlong two-byte form of an ASCII character
                    cp = 21'($urandom_range(0, 127));
                    add_str_byte({3'b110, 3'b000, cp[7:6]});
                    add_str_byte({2'b10, cp[5:0]});
                end
            endcase
        end
        // cut some strings short at a random point, so some end inside a sequence
        if (!cjk_heavy && str_bytes.size() > 1 && $urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, str_bytes.size() - 1);
            while (str_bytes.size() > cut) void'(str_bytes.pop_back());
        end
        send_built_string();
    endtask

    task automatic test_ascii_range();
        // last word is dropped, so the string closes with a bare end marker
        str_bytes = '{8'h00, 8'h30, 8'h39, 8'h41, 8'h5A, 8'h5B, 8'h7A, 8'h7F};
        send_built_string();
    endtask

    task automatic test_multibyte();
        // range edges, stray bytes, overlong 4-byte, lead inside a sequence,
        // full sequence closing the string
        str_bytes = '{8'hE4, 8'hB8, 8'h80, 8'h80, 8'hFF, 8'hF0, 8'h80, 8'h80, 8'hB1,
                      8'hE4, 8'hC3, 8'h80, 8'hE9, 8'hBF, 8'hBF};
        send_built_string();
    endtask

    task automatic test_truncated_tail();
        str_bytes = '{8'hE4, 8'h41};
        send_built_string();
        // the trailing lead cannot complete either
        str_bytes = '{8'hF0, 8'h31, 8'hE5};
        send_built_string();
    endtask

    task automatic test_random_strings();
        int unsigned stop_at;
        stop_at = words_sent + 40;
        while (words_sent < stop_at) send_random_string(1'b0);
    endtask

    task automatic test_output_backpressure();
        int unsigned stop_at;
        tx_idle_en    = 1'b0;
        long_hold_req = 1'b1;
        stop_at       = words_sent + 24;
        while (words_sent < stop_at) send_random_string(1'b1);
        tx_idle_en = 1'b1;
    endtask

    task automatic test_no_idle();
        int unsigned stop_at;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        stop_at    = words_sent + 15;
        while (words_sent < stop_at) send_random_string(1'b0);
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_in_byte <= 8'h00;
        i_is_last <= 1'b0;
        clear_seq();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ascii_range();
        test_multibyte();
        test_truncated_tail();
        test_random_strings();
        test_output_backpressure();
        test_no_idle();

        i_valid <= 1'b0;
        while (norm_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- utf8_title_normalizer.f -----
hw/rtl/utf8tn_pkg.sv
hw/rtl/utf8tn_decode.sv
hw/rtl/utf8tn_outq.sv
hw/rtl/utf8_title_normalizer.sv
sim/utf8_title_normalizer_test.sv
